FILE: src/light_proxy_bounding_volume_top_macros.svh
// Assertion macros for the light proxy bounding volume block.
`ifndef LIGHT_PROXY_BOUNDING_VOLUME_TOP_MACROS_SVH
`define LIGHT_PROXY_BOUNDING_VOLUME_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define LPBV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define LPBV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: src/lpbv_pkg.sv
// ----------------------------------------------------------------------------
// lpbv_pkg
// Shared types and constants of the light proxy bounding volume block.
// ----------------------------------------------------------------------------
`default_nettype none
package lpbv_pkg;
    localparam int MAX_VERTICES_DEF = 1024;
    localparam logic [31:0] MARGIN_Q16 = 32'd66;
    localparam logic [63:0] K_SPHERE_VOL = 64'd274517;
    localparam logic [63:0] K_TWO_PI = 64'd411775;
    localparam logic [31:0] STRENGTH_LIMIT = 32'd25856;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic        last_vertex;
    } t_in_beat;

    typedef struct packed {
        logic        proxy_kind;
        logic [31:0] first_x;
        logic [31:0] first_y;
        logic [31:0] first_z;
        logic [31:0] second_x;
        logic [31:0] second_y;
        logic [31:0] second_z;
        logic [31:0] sphere_radius;
        logic [63:0] radiosity;
    } t_out_beat;

    // Multiplier unit request / response: start / done handshake
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [63:0] q;
    } t_mul_rsp;
endpackage
`default_nettype wire

FILE: src/lpbv_if.sv
// ----------------------------------------------------------------------------
// lpbv_in_if / lpbv_out_if
// Valid/ready channels carrying vertex beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none
interface lpbv_in_if;
    logic              valid;
    logic              ready;
    lpbv_pkg::t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lpbv_out_if;
    logic               valid;
    logic               ready;
    lpbv_pkg::t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/lpbv_ram.sv
// ----------------------------------------------------------------------------
// lpbv_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module lpbv_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: src/lpbv_mul.sv
// ----------------------------------------------------------------------------
// lpbv_mul
// Shared Q48.16 saturating multiplier: floor(a*b/2^16), four 32x32 partials.
// ----------------------------------------------------------------------------
`default_nettype none
module lpbv_mul (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lpbv_pkg::t_mul_req i_req,
    output lpbv_pkg::t_mul_rsp      o_rsp
);
    logic [63:0]  r_a, r_b;
    logic [2:0]   r_step;
    logic         r_busy;
    logic [127:0] r_acc;
    logic [63:0]  r_prod;
    logic [31:0]  w_x, w_y;
    logic [6:0]   w_sh;
    logic         r_pv;
    logic [6:0]   r_psh;
    logic [127:0] w_sum;

    always_comb begin
        case (r_step[1:0])
            2'd0: begin w_x = r_a[31:0];  w_y = r_b[31:0];  w_sh = 7'd0;  end
            2'd1: begin w_x = r_a[31:0];  w_y = r_b[63:32]; w_sh = 7'd32; end
            2'd2: begin w_x = r_a[63:32]; w_y = r_b[31:0];  w_sh = 7'd32; end
            default: begin w_x = r_a[63:32]; w_y = r_b[63:32]; w_sh = 7'd64; end
        endcase
        w_sum = r_acc + ({64'd0, r_prod} << r_psh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
            o_rsp.done <= 1'b0;
        end else begin
            o_rsp.done <= 1'b0;
            r_pv <= 1'b0;
            if (i_req.start) begin
                r_a <= i_req.a;
                r_b <= i_req.b;
                r_step <= 3'd0;
                r_busy <= 1'b1;
                r_acc <= '0;
            end else if (r_busy) begin
                r_prod <= 64'(w_x) * 64'(w_y);
                r_psh <= w_sh;
                r_pv <= (r_step < 3'd4);
                if (r_pv) r_acc <= w_sum;
                r_step <= r_step + 3'd1;
                // all four partials are in r_acc by the last step
                if (r_step == 3'd5) begin
                    r_busy <= 1'b0;
                    o_rsp.done <= 1'b1;
                    o_rsp.q <= (|r_acc[127:80]) ? '1 : r_acc[79:16];
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: src/light_proxy_bounding_volume_top.sv
// ----------------------------------------------------------------------------
// light_proxy_bounding_volume_top
// Bounding sphere or box proxy for one emissive primitive.
// ----------------------------------------------------------------------------
// Usage:
//  - i_vtx (valid/ready) carries one vertex beat per cycle while loading and
//    no result pending; it goes to the vertex RAM and widens the running box.
//  - A beat with last_vertex set starts the final pass: ready drops, the
//    center is taken, every stored vertex is read back (S_RD, S_RDW) and
//    its 3 exact squares are formed on the shared multiplier, the 64-bit
//    square root runs, the margin is added, then 7 (sphere) or 9 (box)
//    products follow.
//  - If emissive_strength is at or below 1.01, or no vertex was stored, no
//    result beat is produced and ready returns via S_DEC and S_NXT.
//  - o_res (valid/ready) holds a result beat until taken; the block stays
//    not ready until the receiver accepts it and the state is back in S_LOAD.
//  - i_cfg_we/i_cfg_data write emissive_strength; write only when idle.
//  - Reset (synchronous, active low) clears count, box and strength.
// ----------------------------------------------------------------------------
`default_nettype none
`include "light_proxy_bounding_volume_top_macros.svh"
module light_proxy_bounding_volume_top #(
    parameter int MAX_VERTICES = lpbv_pkg::MAX_VERTICES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    lpbv_in_if.sink          i_vtx,
    lpbv_out_if.source       o_res
);
    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [10:0] {
        S_LOAD  = 11'b00000000001,
        S_DIST  = 11'b00000000010,
        S_DMUL  = 11'b00000000100,
        S_SQRT  = 11'b00000001000,
        S_PREP  = 11'b00000010000,
        S_MUL   = 11'b00000100000,
        S_DEC   = 11'b00001000000,
        S_OUT   = 11'b00010000000,
        S_RD    = 11'b00100000000,
        S_RDW   = 11'b01000000000,
        S_NXT   = 11'b10000000000
    } t_state;

    t_state r_state;
    logic [15:0] r_str;
    logic [CW-1:0] r_cnt, r_idx;
    logic signed [31:0] r_min [3];
    logic signed [31:0] r_max [3];
    logic signed [31:0] r_c [3];
    logic [95:0] w_rdata;
    logic [63:0] r_best, r_d2;
    logic [1:0]  r_ax;
    logic [3:0]  r_op;
    logic [5:0]  r_it;
    logic [63:0] r_sv, r_sres;
    logic [63:0] r_rad, r_t0, r_t1, r_vs, r_area;
    logic [63:0] r_e [3];
    logic [31:0] r_lo [3];
    logic [31:0] r_hi [3];
    logic        r_kind;
    logic        r_ovalid;
    lpbv_pkg::t_out_beat r_obeat;
    lpbv_pkg::t_mul_req  w_mreq;
    lpbv_pkg::t_mul_rsp  w_mrsp;
    logic [63:0] r_ma, r_mb;
    logic        r_mstart;

    wire w_acc = i_vtx.valid && i_vtx.ready;
    wire w_store = w_acc && (r_cnt < CW'(MAX_VERTICES));
    wire w_emit = (32'(r_str) * 32'd100) > lpbv_pkg::STRENGTH_LIMIT;

    assign i_vtx.ready = (r_state == S_LOAD) && !r_ovalid;
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_obeat;

    lpbv_ram #(.WIDTH(96), .DEPTH(MAX_VERTICES)) u_ram (
        .i_clk(i_clk), .i_we(w_store), .i_waddr(r_cnt[AW-1:0]),
        .i_wdata({i_vtx.data.pos_x, i_vtx.data.pos_y, i_vtx.data.pos_z}),
        .i_raddr(r_idx[AW-1:0]), .o_rdata(w_rdata));

    assign w_mreq = '{start: r_mstart, a: r_ma, b: r_mb};
    lpbv_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_mreq), .o_rsp(w_mrsp));

    // distance of current axis
    logic signed [32:0] w_d;
    logic [32:0] w_ad;
    logic [63:0] w_ad2;
    logic signed [32:0] w_sum [3];
    logic [64:0] w_dsum;
    logic [64:0] w_asum;
    always_comb begin
        case (r_ax)
            2'd0: w_d = 33'(signed'(w_rdata[95:64])) - 33'(r_c[0]);
            2'd1: w_d = 33'(signed'(w_rdata[63:32])) - 33'(r_c[1]);
            default: w_d = 33'(signed'(w_rdata[31:0])) - 33'(r_c[2]);
        endcase
        w_ad = w_d[32] ? 33'(-w_d) : 33'(w_d);
        // |d| never exceeds 2^31 since the center lies inside the box
        w_ad2 = 64'(w_ad[31:0]);
        for (int a = 0; a < 3; a++) begin
            w_sum[a] = 33'(r_min[a]) + 33'(r_max[a]);
        end
        w_dsum = 65'(r_d2) + 65'(w_mrsp.q);
        w_asum = 65'(r_area) + 65'(w_mrsp.q);
    end

    always_ff @(posedge i_clk) begin
        r_mstart <= 1'b0;
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_str    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_min[a] <= 32'sh7FFFFFFF;
                r_max[a] <= 32'sh80000000;
            end
        end else begin
            if (i_cfg_we) r_str <= i_cfg_data;
            if (r_ovalid && o_res.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (w_store) begin
                        r_cnt <= r_cnt + CW'(1);
                        if (signed'(i_vtx.data.pos_x) < r_min[0]) r_min[0] <= i_vtx.data.pos_x;
                        if (signed'(i_vtx.data.pos_x) > r_max[0]) r_max[0] <= i_vtx.data.pos_x;
                        if (signed'(i_vtx.data.pos_y) < r_min[1]) r_min[1] <= i_vtx.data.pos_y;
                        if (signed'(i_vtx.data.pos_y) > r_max[1]) r_max[1] <= i_vtx.data.pos_y;
                        if (signed'(i_vtx.data.pos_z) < r_min[2]) r_min[2] <= i_vtx.data.pos_z;
                        if (signed'(i_vtx.data.pos_z) > r_max[2]) r_max[2] <= i_vtx.data.pos_z;
                    end
                    if (w_acc && i_vtx.data.last_vertex) begin
                        r_state <= S_DEC;
                        r_idx <= '0;
                        r_best <= '0;
                    end
                end
                S_DEC: begin
                    // center = floor((min+max)/2) via arithmetic shift
                    for (int a = 0; a < 3; a++) r_c[a] <= w_sum[a][32:1];
                    if (!w_emit || r_cnt == '0) r_state <= S_NXT;
                    else r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_RDW;
                end
                S_RDW: begin
                    r_ax <= 2'd0;
                    r_d2 <= '0;
                    r_state <= S_DIST;
                end
                S_DIST: begin
                    // ad * (ad << 16) >> 16 gives the exact square
                    r_ma <= w_ad2;
                    r_mb <= w_ad2 << 16;
                    r_mstart <= 1'b1;
                    r_state <= S_DMUL;
                end
                S_DMUL: begin
                    if (w_mrsp.done) begin
                        r_d2 <= w_dsum[64] ? '1 : w_dsum[63:0];
                        if (r_ax == 2'd2) begin
                            r_idx <= r_idx + CW'(1);
                            if (w_dsum[63:0] > r_best || w_dsum[64]) r_best <= w_dsum[64] ? '1 : w_dsum[63:0];
                            if (r_idx + CW'(1) == r_cnt) begin
                                r_state <= S_SQRT;
                                r_sv <= '0; r_sres <= '0; r_it <= '0;
                            end else r_state <= S_RD;
                        end else begin
                            r_ax <= r_ax + 2'd1;
                            r_state <= S_DIST;
                        end
                    end
                end
                S_SQRT: begin
                    // restoring sqrt: r_sv remainder, r_sres root, r_best shifts out
                    r_sv <= {r_sv[61:0], r_best[63:62]};
                    r_best <= {r_best[61:0], 2'b00};
                    if ({r_sv[61:0], r_best[63:62]} >= {r_sres[61:0], 2'b01}) begin
                        r_sv <= {r_sv[61:0], r_best[63:62]} - {r_sres[61:0], 2'b01};
                        r_sres <= {r_sres[62:0], 1'b1};
                    end else r_sres <= {r_sres[62:0], 1'b0};
                    r_it <= r_it + 6'd1;
                    if (r_it == 6'd31) r_state <= S_PREP;
                end
                S_PREP: begin
                    r_rad <= (r_sres + 64'(lpbv_pkg::MARGIN_Q16) > 64'hFFFFFFFF) ?
                             64'hFFFFFFFF : r_sres + 64'(lpbv_pkg::MARGIN_Q16);
                    for (int a = 0; a < 3; a++) begin
                        r_lo[a] <= (r_min[a] < -32'sd2147483582) ? 32'h80000000
                                   : 32'(r_min[a] - 32'sd66);
                        r_hi[a] <= (r_max[a] > 32'sd2147483581) ? 32'h7FFFFFFF
                                   : 32'(r_max[a] + 32'sd66);
                    end
                    r_op <= 4'd0;
                    r_state <= S_MUL;
                    r_mstart <= 1'b0;
                end
                S_MUL: begin
                    if (r_op == 4'd0) begin
                        for (int a = 0; a < 3; a++)
                            r_e[a] <= 64'(33'(signed'(r_hi[a])) - 33'(signed'(r_lo[a])));
                        r_ma <= r_rad; r_mb <= r_rad; r_mstart <= 1'b1; r_op <= 4'd1;
                    end else if (w_mrsp.done) begin
                        r_mstart <= 1'b1;
                        r_op <= r_op + 4'd1;
                        case (r_op)
                            4'd1: begin r_t0 <= w_mrsp.q; r_ma <= r_rad; r_mb <= w_mrsp.q; end
                            4'd2: begin r_ma <= lpbv_pkg::K_SPHERE_VOL; r_mb <= w_mrsp.q; end
                            4'd3: begin r_vs <= w_mrsp.q; r_ma <= r_e[1]; r_mb <= r_e[2]; end
                            4'd4: begin r_ma <= r_e[0]; r_mb <= w_mrsp.q; end
                            4'd5: begin
                                r_kind <= !(r_vs < w_mrsp.q);
                                if (r_vs < w_mrsp.q) begin
                                    r_ma <= lpbv_pkg::K_TWO_PI; r_mb <= r_t0; r_op <= 4'd6;
                                end else begin
                                    r_ma <= r_e[0]; r_mb <= r_e[1]; r_op <= 4'd8;
                                end
                            end
                            4'd6: begin r_ma <= w_mrsp.q; r_mb <= 64'(r_str) << 8; r_op <= 4'd7; end
                            4'd7: begin r_t1 <= w_mrsp.q; r_mstart <= 1'b0; r_state <= S_OUT; end
                            4'd8: begin r_area <= w_mrsp.q; r_ma <= r_e[2]; r_mb <= r_e[1]; end
                            4'd9: begin
                                r_area <= w_asum[64] ? '1 : w_asum[63:0];
                                r_ma <= r_e[0]; r_mb <= r_e[2];
                            end
                            4'd10: begin
                                r_ma <= w_asum[64] ? '1 : w_asum[63:0];
                                r_mb <= 64'(r_str) << 8;
                            end
                            default: begin r_t1 <= w_mrsp.q; r_mstart <= 1'b0; r_state <= S_OUT; end
                        endcase
                    end
                end
                S_OUT: begin
                    r_obeat.proxy_kind <= r_kind;
                    r_obeat.radiosity <= r_t1;
                    if (!r_kind) begin
                        r_obeat.first_x <= r_c[0]; r_obeat.first_y <= r_c[1];
                        r_obeat.first_z <= r_c[2];
                        r_obeat.second_x <= '0; r_obeat.second_y <= '0; r_obeat.second_z <= '0;
                        r_obeat.sphere_radius <= r_rad[31:0];
                    end else begin
                        r_obeat.first_x <= r_lo[0]; r_obeat.first_y <= r_lo[1];
                        r_obeat.first_z <= r_lo[2];
                        r_obeat.second_x <= r_hi[0]; r_obeat.second_y <= r_hi[1];
                        r_obeat.second_z <= r_hi[2];
                        r_obeat.sphere_radius <= '0;
                    end
                    r_ovalid <= 1'b1;
                    r_state <= S_NXT;
                end
                S_NXT: begin
                    r_cnt <= '0;
                    for (int a = 0; a < 3; a++) begin
                        r_min[a] <= 32'sh7FFFFFFF;
                        r_max[a] <= 32'sh80000000;
                    end
                    r_state <= S_LOAD;
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    `LPBV_ASSERT_IMPL(a_rdy_load, i_clk, i_rst_n, i_vtx.ready, r_state == S_LOAD, "ready outside load")
    `LPBV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_res.valid && !o_res.ready, o_res.valid, "result dropped")
    `LPBV_ASSERT_IMPL(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(MAX_VERTICES), "count overflow")
endmodule
`default_nettype wire
